>>> hw/rtl/erot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erot_pkg: shared types, constants and functions for the euler rotator
// sine/cosine magnitude tables built at elaboration, fixed-point multiply
// ----------------------------------------------------------------------------
package erot_pkg;

	localparam int FracBits  = 16;
	localparam int TableSize = 360;
	localparam int TrigW     = 18;
	localparam int QDepth    = 4;
	localparam int QAw       = $clog2(QDepth);

	// q62 constants of the table builder
	localparam logic [63:0] PiQ62      = 64'hC90FDAA22168C234;
	localparam logic [63:0] PiStep     = PiQ62 / 64'd180;
	localparam logic [63:0] RoundGuard = 64'd4096;
	localparam int          QShift     = 62;

	typedef logic [89:0][16:0] mag_tab_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [8:0]         ang_x;
		logic [8:0]         ang_y;
		logic [8:0]         ang_z;
	} vtx_in_t;

	typedef struct packed {
		logic signed [TrigW-1:0] s;
		logic signed [TrigW-1:0] c;
	} trig_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		trig_t              tx;
		trig_t              ty;
		trig_t              tz;
	} item_t;

	// (a*b) >> 62 on q62 operands, low 64 bits kept
	function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// taylor series for 0..45 degrees, q62 result
	function automatic logic [63:0] series(input int deg, input logic want_sin);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] ts;
		logic [63:0] tc;
		logic [63:0] ss;
		logic [63:0] cc;
		x  = 64'(deg) * PiStep;
		x2 = mulq(x, x);
		ts = x;
		tc = 64'd1 << QShift;
		ss = x;
		cc = tc;
		for (int n = 1; n <= 14; n++) begin
			ts = mulq(ts, x2) / 64'((2 * n) * (2 * n + 1));
			tc = mulq(tc, x2) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) begin
				ss = ss - ts;
				cc = cc - tc;
			end else begin
				ss = ss + ts;
				cc = cc + tc;
			end
		end
		return want_sin ? ss : cc;
	endfunction

	// first-quadrant magnitudes in FracBits format, truncated toward zero
	function automatic mag_tab_t build_tab(input logic want_sin);
		mag_tab_t    t;
		logic [63:0] m;
		logic [63:0] v;
		for (int a = 0; a < 90; a++) begin
			if (a <= 45) begin
				m = series(a, want_sin);
			end else begin
				m = series(90 - a, !want_sin);
			end
			v = (m + RoundGuard) >> (QShift - FracBits);
			t[a] = v[16:0];
		end
		return t;
	endfunction

	localparam mag_tab_t SinMag = build_tab(1'b1);
	localparam mag_tab_t CosMag = build_tab(1'b0);

	// whole-degree angle to signed sine and cosine
	function automatic trig_t trig_lookup(input logic [8:0] ang);
		logic [9:0]  r;
		logic [1:0]  q;
		logic [9:0]  a;
		logic [16:0] ms;
		logic [16:0] mc;
		logic [16:0] vs;
		logic [16:0] vc;
		trig_t       res;
		r = {1'b0, ang};
		if (r >= 10'(TableSize)) begin
			r = r - 10'(TableSize);
		end
		if (r >= 10'd270) begin
			q = 2'd3;
			a = r - 10'd270;
		end else if (r >= 10'd180) begin
			q = 2'd2;
			a = r - 10'd180;
		end else if (r >= 10'd90) begin
			q = 2'd1;
			a = r - 10'd90;
		end else begin
			q = 2'd0;
			a = r;
		end
		ms = SinMag[a[6:0]];
		mc = CosMag[a[6:0]];
		// odd quadrants swap sine and cosine
		vs = q[0] ? mc : ms;
		vc = q[0] ? ms : mc;
		res.s = q[1] ? -$signed({1'b0, vs}) : $signed({1'b0, vs});
		res.c = (q[0] ^ q[1]) ? -$signed({1'b0, vc}) : $signed({1'b0, vc});
		return res;
	endfunction

	// fixed-point multiply: full product, arithmetic shift, low 32 bits
	function automatic logic signed [31:0] fxmul(input logic signed [31:0] a,
			input logic signed [TrigW-1:0] b);
		logic signed [31+TrigW:0] p;
		p = a * b;
		return p[FracBits+31:FracBits];
	endfunction

endpackage

>>> hw/rtl/erot_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erot_front: input stage
// reduces the three angles, reads the trig tables, registers the work item
// ----------------------------------------------------------------------------
module erot_front import erot_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  vtx_in_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output item_t   out_data
);

	logic  valid_q;
	item_t item_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q.x  <= in_data.x;
			item_q.y  <= in_data.y;
			item_q.z  <= in_data.z;
			item_q.tx <= trig_lookup(in_data.ang_x);
			item_q.ty <= trig_lookup(in_data.ang_y);
			item_q.tz <= trig_lookup(in_data.ang_z);
		end
	end

endmodule

>>> hw/rtl/erot_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erot_fifo: short queue between front and back
// register based, one write and one read port
// ----------------------------------------------------------------------------
module erot_fifo import erot_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  item_t        in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output item_t        out_data,
	output logic [QAw:0] count
);

	item_t          mem_q [QDepth];
	logic [QAw-1:0] wr_ptr_q;
	logic [QAw-1:0] rd_ptr_q;
	logic [QAw:0]   count_q;
	logic           push;
	logic           pop;

	assign in_ready  = count_q != (QAw+1)'(QDepth);
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign count     = count_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

>>> hw/rtl/erot_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erot_back: rotation pipeline
// stage 1 about x, stage 2 about y, stage 3 about z and output register
// ----------------------------------------------------------------------------
module erot_back import erot_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  item_t              in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic rdy1;
	logic rdy2;
	logic rdy3;

	logic signed [31:0] x_s1;
	logic signed [31:0] y1_s1;
	logic signed [31:0] z1_s1;
	trig_t              ty_s1;
	trig_t              tz_s1;

	logic signed [31:0] x1_s2;
	logic signed [31:0] y1_s2;
	logic signed [31:0] z2_s2;
	trig_t              tz_s2;

	logic signed [31:0] x2_s3;
	logic signed [31:0] y2_s3;
	logic signed [31:0] z2_s3;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign out_valid = v_s3;
	assign out_x     = x2_s3;
	assign out_y     = y2_s3;
	assign out_z     = z2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// about x
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			x_s1  <= in_data.x;
			y1_s1 <= fxmul(in_data.y, in_data.tx.c) - fxmul(in_data.z, in_data.tx.s);
			z1_s1 <= fxmul(in_data.y, in_data.tx.s) + fxmul(in_data.z, in_data.tx.c);
			ty_s1 <= in_data.ty;
			tz_s1 <= in_data.tz;
		end
	end

	// about y
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			x1_s2 <= fxmul(x_s1, ty_s1.c) + fxmul(z1_s1, ty_s1.s);
			z2_s2 <= fxmul(z1_s1, ty_s1.c) - fxmul(x_s1, ty_s1.s);
			y1_s2 <= y1_s1;
			tz_s2 <= tz_s1;
		end
	end

	// about z
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			x2_s3 <= fxmul(x1_s2, tz_s2.c) - fxmul(y1_s2, tz_s2.s);
			y2_s3 <= fxmul(x1_s2, tz_s2.s) + fxmul(y1_s2, tz_s2.c);
			z2_s3 <= z2_s2;
		end
	end

endmodule

>>> hw/rtl/euler_xyz_rotate_fixed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_xyz_rotate_fixed: fixed-point 3d rotation about x, then y, then z
// angles in whole degrees, vertex in signed q.16, results wrap at 32 bits
// ----------------------------------------------------------------------------
//  channel  | dir | payload (lsb first)                           | bits
//  s_axis   | in  | x, y, z (32 each), angle x, y, z (9 each)     | 128
//  m_axis   | out | x, y, z (32 each), rotated                    | 96
//
//  one vertex per cycle sustained while m_axis_tready stays high; the data path
//  runs through the front register, the queue and three multiply stages of the back pipeline
//  the front reduces angles and reads the trig tables, the back rotates
//  a four-entry queue lets the front keep taking transactions while the
//  back is stalled by m_axis_tready
//  arst_n clears all valid and queue state, no clearing pass is needed
// ----------------------------------------------------------------------------
module euler_xyz_rotate_fixed import erot_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // in_x, in_y, in_z, angle_x, angle_y, angle_z, zero pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata   // out_x, out_y, out_z
);

	vtx_in_t      vin;
	logic         f_valid;
	logic         f_ready;
	item_t        f_data;
	logic         q_valid;
	logic         q_ready;
	item_t        q_data;
	logic [QAw:0] q_count;
	logic signed [31:0] rx;
	logic signed [31:0] ry;
	logic signed [31:0] rz;

	// unpack the input transaction
	assign vin.x     = s_axis_tdata[31:0];
	assign vin.y     = s_axis_tdata[63:32];
	assign vin.z     = s_axis_tdata[95:64];
	assign vin.ang_x = s_axis_tdata[104:96];
	assign vin.ang_y = s_axis_tdata[113:105];
	assign vin.ang_z = s_axis_tdata[122:114];

	// front: angle reduction and table reads
	erot_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (vin),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	// decoupling queue
	erot_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data),
		.count     (q_count)
	);

	// back: three rotation stages and the output register
	erot_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_data   (q_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_x     (rx),
		.out_y     (ry),
		.out_z     (rz)
	);

	assign m_axis_tdata = {rz, ry, rx};

	// queue never takes a transaction while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && f_ready) |-> (q_count != (QAw+1)'(QDepth)))
		else $error("queue written while full");

	// queue fill stays within its depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= (QAw+1)'(QDepth))
		else $error("queue count out of range");

	// a queued item is offered to the back every cycle it sits there
	a_queue_offers: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count != '0) |-> q_valid)
		else $error("queue holds an item but shows no valid");

	// a stalled front item is still there in the following cycle
	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && !f_ready) |=> f_valid)
		else $error("front item dropped while queue full");

endmodule
